FILE: hdl/fixed_record_delimiter_inserter_defines.svh
// assertion macros for the record delimiter inserter
`ifndef FIXED_RECORD_DELIMITER_INSERTER_DEFINES_SVH
`define FIXED_RECORD_DELIMITER_INSERTER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FRDI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frdi assertion failed");
// next-cycle implication
`define FRDI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frdi assertion failed");
`else
`define FRDI_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define FRDI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/frdi_pkg.sv
package frdi_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] REG_RECORD_LENGTH    = 2'd0;
	localparam logic [1:0] REG_DELIMITER_LENGTH = 2'd1;
	localparam logic [1:0] REG_DELIMITER_FIRST  = 2'd2;
	localparam logic [1:0] REG_DELIMITER_SECOND = 2'd3;

	// input item kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_EOS  = 1'b1;

	// byte order mark
	localparam logic [7:0] BOM_0 = 8'hef;
	localparam logic [7:0] BOM_1 = 8'hbb;
	localparam logic [7:0] BOM_2 = 8'hbf;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_inserted;
		logic       last;
	} out_item_t;

	// group of one to three bytes queued for the emitter
	typedef struct packed {
		logic            pass;   // byte order mark: bytes go out uncounted
		logic [1:0]      count;  // number of bytes, 1 to 3
		logic [2:0][7:0] bytes;
	} job_t;

	typedef enum logic [1:0] {
		PH_CHAR,
		PH_DELIM2,
		PH_BYTE
	} phase_t;

	// continuation bytes that follow a utf-8 lead byte
	function automatic logic [1:0] cont_count(input logic utf8, input logic [7:0] b);
		logic [1:0] n;
		n = 2'd0;
		if (utf8 && b[7]) begin
			if (!b[6])
				n = 2'd0;
			else if (!b[5])
				n = 2'd1;
			else if (!b[4])
				n = 2'd2;
			else
				n = 2'd3;
		end
		return n;
	endfunction

endpackage

FILE: hdl/fixed_record_delimiter_inserter.sv
// Fixed-length record delimiter inserter. Bytes go out one per cycle unless
// stalled: each data byte gives one output byte, plus one per inserted
// delimiter byte, so an input transfer gives 1 to 3 results, up to 9 when
// the held three-byte prefix is released at once. The rate is set by the
// emitter, which puts one result a cycle into the output register while it
// is free. A two-entry queue between input and emitter lets a new transfer
// be taken while results are still going out. Transfers that only store
// a prefix byte, and an end of stream with nothing held, give no result.
`include "fixed_record_delimiter_inserter_defines.svh"

module fixed_record_delimiter_inserter import frdi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,
	// output stream
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item
);

	logic [15:0] record_length_q;
	logic [1:0]  delimiter_length_q;
	logic [7:0]  delimiter_first_q;
	logic [7:0]  delimiter_second_q;
	logic        cfg_wr;
	logic [1:0]  cfg_idx;

	logic [1:0]  prefix_count_q;
	logic [7:0]  prefix_bytes_q [2];
	logic        mode_decided_q;
	logic        utf8_mode_q;

	job_t        q_entry_q [2];
	logic        q_wr_ptr_q, q_rd_ptr_q;
	logic [1:0]  q_count_q;
	logic        in_fire, push, pop;
	job_t        push_job;
	logic        is_bom;

	// register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_length_q    <= 16'd80;
			delimiter_length_q <= 2'd1;
			delimiter_first_q  <= 8'd10;
			delimiter_second_q <= 8'd10;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_RECORD_LENGTH:    record_length_q    <= pwdata[15:0];
				REG_DELIMITER_LENGTH: delimiter_length_q <= pwdata[1:0];
				REG_DELIMITER_FIRST:  delimiter_first_q  <= pwdata[7:0];
				REG_DELIMITER_SECOND: delimiter_second_q <= pwdata[7:0];
				default:              record_length_q    <= record_length_q;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_RECORD_LENGTH:    prdata = {16'd0, record_length_q};
			REG_DELIMITER_LENGTH: prdata = {30'd0, delimiter_length_q};
			REG_DELIMITER_FIRST:  prdata = {24'd0, delimiter_first_q};
			REG_DELIMITER_SECOND: prdata = {24'd0, delimiter_second_q};
			default:              prdata = 32'd0;
		endcase
	end

	// input side: room in the queue
	assign in_ready = (q_count_q != 2'd2);
	assign in_fire  = in_valid && in_ready;

	assign is_bom = (prefix_bytes_q[0] == BOM_0) && (prefix_bytes_q[1] == BOM_1) &&
		(in_item.data_byte == BOM_2);

	// prefix decode: which bytes this transfer releases
	always_comb begin
		push           = 1'b0;
		push_job.pass  = 1'b0;
		push_job.count = 2'd1;
		push_job.bytes = {in_item.data_byte, prefix_bytes_q[1], prefix_bytes_q[0]};
		if (in_item.kind == KIND_EOS) begin
			if (!mode_decided_q && prefix_count_q != 2'd0) begin
				push           = 1'b1;
				push_job.count = prefix_count_q;
			end
		end else if (!mode_decided_q) begin
			if (prefix_count_q == 2'd2) begin
				push           = 1'b1;
				push_job.count = 2'd3;
				push_job.pass  = is_bom;
			end
		end else begin
			push           = 1'b1;
			push_job.bytes = {8'd0, 8'd0, in_item.data_byte};
		end
	end

	// prefix and mode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_count_q <= 2'd0;
			mode_decided_q <= 1'b0;
			utf8_mode_q    <= 1'b0;
		end else if (in_fire && !mode_decided_q) begin
			if (in_item.kind == KIND_EOS) begin
				if (prefix_count_q != 2'd0) begin
					mode_decided_q <= 1'b1;
					utf8_mode_q    <= 1'b0;
					prefix_count_q <= 2'd0;
				end
			end else if (prefix_count_q == 2'd2) begin
				mode_decided_q <= 1'b1;
				utf8_mode_q    <= is_bom;
				prefix_count_q <= 2'd0;
			end else begin
				prefix_count_q <= prefix_count_q + 2'd1;
			end
		end
	end

	// held prefix bytes
	always_ff @(posedge clk) begin
		if (in_fire && !mode_decided_q && in_item.kind == KIND_DATA &&
			prefix_count_q != 2'd2) begin
			prefix_bytes_q[prefix_count_q[0]] <= in_item.data_byte;
		end
	end

	// two-entry queue of byte groups
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_ptr_q <= 1'b0;
			q_rd_ptr_q <= 1'b0;
			q_count_q  <= 2'd0;
		end else begin
			if (in_fire && push)
				q_wr_ptr_q <= ~q_wr_ptr_q;
			if (pop)
				q_rd_ptr_q <= ~q_rd_ptr_q;
			q_count_q <= q_count_q + {1'b0, in_fire && push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && push)
			q_entry_q[q_wr_ptr_q] <= push_job;
	end

	frdi_emit u_emit (
		.clk              (clk),
		.arst_n           (arst_n),
		.record_length    (record_length_q),
		.delimiter_length (delimiter_length_q),
		.delimiter_first  (delimiter_first_q),
		.delimiter_second (delimiter_second_q),
		.utf8_mode        (utf8_mode_q),
		.head_valid       (q_count_q != 2'd0),
		.head             (q_entry_q[q_rd_ptr_q]),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_item         (out_item)
	);

	// checks
	`FRDI_ASSERT_NOW(a_pop_needs_entry, clk, arst_n, pop, q_count_q != 2'd0)
	`FRDI_ASSERT_NOW(a_queue_bound, clk, arst_n, 1'b1, q_count_q <= 2'd2)
	`FRDI_ASSERT_NOW(a_prefix_undecided, clk, arst_n, prefix_count_q != 2'd0, !mode_decided_q)
	`FRDI_ASSERT_NOW(a_utf8_decided, clk, arst_n, utf8_mode_q, mode_decided_q)

endmodule

FILE: hdl/frdi_emit.sv
module frdi_emit import frdi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] record_length,
	input  logic [1:0]  delimiter_length,
	input  logic [7:0]  delimiter_first,
	input  logic [7:0]  delimiter_second,
	input  logic        utf8_mode,
	input  logic        head_valid,
	input  job_t        head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item
);

	phase_t      phase_q, phase_d;
	logic [1:0]  idx_q;
	logic [15:0] char_pos_q, pos_d;
	logic [1:0]  cont_q, cont_d;
	logic        out_valid_q;
	out_item_t   out_item_q, em;
	logic        advance, byte_done, is_last_byte, overflow;
	logic [16:0] next_pos;
	logic [7:0]  cur_byte;

	// one result per cycle while the output register is free
	assign advance = head_valid && (!out_valid_q || out_ready);

	// current byte of the head group
	assign cur_byte = (idx_q == 2'd2) ? head.bytes[2] :
		(idx_q[0] ? head.bytes[1] : head.bytes[0]);
	assign is_last_byte = (idx_q == (head.count - 2'd1));

	// record position check
	assign next_pos = {1'b0, char_pos_q} + 17'd1;
	assign overflow = next_pos > {1'b0, record_length};

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_CHAR: begin
				if (!head.pass && cont_q == 2'd0 && overflow)
					phase_d = delimiter_length[1] ? PH_DELIM2 : PH_BYTE;
			end
			PH_DELIM2: phase_d = PH_BYTE;
			PH_BYTE:   phase_d = PH_CHAR;
			default:   phase_d = PH_CHAR;
		endcase
	end

	// result and counting state for this cycle
	always_comb begin
		em.out_byte    = cur_byte;
		em.is_inserted = 1'b0;
		byte_done      = 1'b0;
		pos_d          = char_pos_q;
		cont_d         = cont_q;
		case (phase_q)
			PH_CHAR: begin
				if (head.pass) begin
					byte_done = 1'b1;
				end else if (cont_q != 2'd0) begin
					cont_d    = cont_q - 2'd1;
					byte_done = 1'b1;
				end else if (overflow) begin
					em.out_byte    = delimiter_first;
					em.is_inserted = 1'b1;
					pos_d          = 16'd1;
				end else begin
					pos_d     = next_pos[15:0];
					cont_d    = cont_count(utf8_mode, cur_byte);
					byte_done = 1'b1;
				end
			end
			PH_DELIM2: begin
				em.out_byte    = delimiter_second;
				em.is_inserted = 1'b1;
			end
			PH_BYTE: begin
				cont_d    = cont_count(utf8_mode, cur_byte);
				byte_done = 1'b1;
			end
			default: begin
				byte_done = 1'b0;
			end
		endcase
		em.last = byte_done && is_last_byte;
	end

	assign pop = advance && byte_done && is_last_byte;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CHAR;
			idx_q       <= 2'd0;
			char_pos_q  <= 16'd0;
			cont_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q    <= phase_d;
				char_pos_q <= pos_d;
				cont_q     <= cont_d;
				if (pop)
					idx_q <= 2'd0;
				else if (byte_done)
					idx_q <= idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (advance)
			out_item_q <= em;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

FILE: tb/fixed_record_delimiter_inserter_test.sv
module fixed_record_delimiter_inserter_test;
	import frdi_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_BYTES = 75;
	localparam int NUM_PHASES = 6;
	localparam int MAX_REPORTS = 40;

	// one line of the directed table: a register write or an input transfer
	typedef struct packed {
		bit              is_cfg;
		logic [1:0]      reg_idx;
		logic [31:0]     reg_value;
		in_item_t        item;
		int              n_typed;  // -1: results come from the record model
		out_item_t [2:0] typed;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_item;

	// record model: configuration and framing state
	logic [15:0] rec_len;
	logic [1:0]  delim_len;
	logic [7:0]  delim_a;
	logic [7:0]  delim_b;
	logic [1:0]  held_count;
	logic [7:0]  held_bytes [2];
	bit          mode_known;
	bit          utf8_on;
	logic [15:0] char_pos;
	logic [1:0]  cont_left;

	out_item_t   expected_bytes [$];
	out_item_t   front_byte;
	stim_row_t   directed_rows [$];
	int          mismatches = 0;
	int          cycles = 0;
	int          data_sent = 0;
	bit          calm = 1'b0;

	fixed_record_delimiter_inserter dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// random idle cycle, none while calm
	function automatic bit idle_draw();
		return !calm && ($urandom_range(0, 99) < 37);
	endfunction

	function automatic void push_out(logic [7:0] b, logic ins);
		out_item_t r;
		r.out_byte = b;
		r.is_inserted = ins;
		r.last = 1'b0;
		expected_bytes.push_back(r);
	endfunction

	// one byte past the prefix: delimiter if the record is full, utf-8 tracking
	function automatic void count_byte(logic [7:0] b);
		logic [16:0] nxt;
		int ones;
		if (cont_left != 2'd0) begin
			cont_left = cont_left - 2'd1;
			push_out(b, 1'b0);
			return;
		end
		nxt = {1'b0, char_pos} + 17'd1;
		if (nxt > {1'b0, rec_len}) begin
			push_out(delim_a, 1'b1);
			if (delim_len[1])
				push_out(delim_b, 1'b1);
			char_pos = 16'd1;
		end else begin
			char_pos = nxt[15:0];
		end
		if (utf8_on && b[7]) begin
			ones = 0;
			while (ones < 4 && b[3'(7 - ones)])
				ones++;
			cont_left = 2'(ones - 1);
		end
		push_out(b, 1'b0);
	endfunction

	// results of one input transfer; returns how many were queued
	function automatic int frame_item(in_item_t it);
		int n_before;
		int i;
		out_item_t tail;
		n_before = expected_bytes.size();
		if (it.kind == KIND_EOS) begin
			if (!mode_known && held_count != 2'd0) begin
				mode_known = 1'b1;
				utf8_on = 1'b0;
				for (i = 0; i < held_count; i++)
					count_byte(held_bytes[1'(i)]);
				held_count = 2'd0;
			end
		end else if (!mode_known) begin
			if (held_count < 2'd2) begin
				held_bytes[held_count[0]] = it.data_byte;
				held_count = held_count + 2'd1;
			end else begin
				mode_known = 1'b1;
				held_count = 2'd0;
				if (held_bytes[0] == BOM_0 && held_bytes[1] == BOM_1 && it.data_byte == BOM_2) begin
					utf8_on = 1'b1;
					push_out(BOM_0, 1'b0);
					push_out(BOM_1, 1'b0);
					push_out(BOM_2, 1'b0);
				end else begin
					utf8_on = 1'b0;
					count_byte(held_bytes[0]);
					count_byte(held_bytes[1]);
					count_byte(it.data_byte);
				end
			end
		end else begin
			count_byte(it.data_byte);
		end
		if (expected_bytes.size() > n_before) begin
			tail = expected_bytes.pop_back();
			tail.last = 1'b1;
			expected_bytes.push_back(tail);
		end
		return expected_bytes.size() - n_before;
	endfunction

	function automatic stim_row_t item_row(logic kind, logic [7:0] b);
		stim_row_t r;
		r = '0;
		r.item.kind = kind;
		r.item.data_byte = b;
		r.n_typed = -1;
		return r;
	endfunction

	// transfer whose results are written out by hand (plain data bytes)
	function automatic stim_row_t typed_row(logic kind, logic [7:0] b, int n,
			logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
		stim_row_t r;
		logic [2:0][7:0] vals;
		int k;
		r = item_row(kind, b);
		r.n_typed = n;
		vals = {b2, b1, b0};
		for (k = 0; k < n; k++) begin
			r.typed[2'(k)].out_byte = vals[2'(k)];
			r.typed[2'(k)].last = (k == n - 1);
		end
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [1:0] idx, logic [31:0] value);
		stim_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.reg_idx = idx;
		r.reg_value = value;
		return r;
	endfunction

	// one transfer on the input channel, predicted at acceptance
	task automatic send_item(input in_item_t it, output int n_new);
		if (idle_draw()) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while (idle_draw());
		end
		in_valid <= 1'b1;
		in_item <= it;
		do
			@(posedge clk);
		while (!in_ready);
		n_new = frame_item(it);
		if (it.kind == KIND_DATA)
			data_sent++;
	endtask

	// stop sending and wait until every expected byte is out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write: setup phase, then access phase
	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_RECORD_LENGTH:    rec_len = value[15:0];
			REG_DELIMITER_LENGTH: delim_len = value[1:0];
			REG_DELIMITER_FIRST:  delim_a = value[7:0];
			REG_DELIMITER_SECOND: delim_b = value[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// one random character: well-formed utf-8 mostly, some noise and end of stream
	task automatic send_char();
		int pick;
		int conts;
		int k;
		int n_new;
		in_item_t it;
		pick = $urandom_range(0, 99);
		conts = 0;
		it.kind = KIND_DATA;
		if (pick < 6) begin
			it.kind = KIND_EOS;
			it.data_byte = 8'($urandom_range(0, 255));
		end else if (pick < 20) begin
			it.data_byte = 8'($urandom_range(0, 255));
		end else if (pick < 50) begin
			it.data_byte = 8'($urandom_range(0, 8'h7f));
		end else if (pick < 70) begin
			it.data_byte = 8'($urandom_range(8'hc0, 8'hdf));
			conts = 1;
		end else if (pick < 85) begin
			it.data_byte = 8'($urandom_range(8'he0, 8'hef));
			conts = 2;
		end else begin
			it.data_byte = 8'($urandom_range(8'hf0, 8'hff));
			conts = 3;
		end
		send_item(it, n_new);
		for (k = 0; k < conts; k++) begin
			it.kind = KIND_DATA;
			it.data_byte = 8'($urandom_range(8'h80, 8'hbf));
			send_item(it, n_new);
		end
	endtask

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	// output side: check each transfer, random stalls
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: byte %0h with nothing expected, expected none, got %0h",
						$time, out_item.out_byte, out_item);
			end else begin
				front_byte = expected_bytes.pop_front();
				check_field("out_byte", front_byte.out_byte, out_item.out_byte);
				check_field("is_inserted", {7'd0, front_byte.is_inserted},
					{7'd0, out_item.is_inserted});
				check_field("last", {7'd0, front_byte.last}, {7'd0, out_item.last});
			end
		end
		out_ready <= !idle_draw();
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		int path;
		int r;
		int k;
		int n_new;
		int phase;
		bit paused;
		stim_row_t row;
		logic [15:0] rl;
		logic [1:0] dl;
		logic [7:0] da;
		logic [7:0] db;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;

		// reset values of the registers and the framing state
		rec_len = 16'd80;
		delim_len = 2'd1;
		delim_a = 8'd10;
		delim_b = 8'd10;
		held_count = 2'd0;
		mode_known = 1'b0;
		utf8_on = 1'b0;
		char_pos = 16'd0;
		cont_left = 2'd0;

		// the prefix is decided once per reset: mark, near miss, or cut short
		path = $urandom_range(0, 3);
		directed_rows.push_back(typed_row(KIND_DATA, BOM_0, 0, 8'h00, 8'h00, 8'h00));
		directed_rows.push_back(typed_row(KIND_DATA, BOM_1, 0, 8'h00, 8'h00, 8'h00));
		case (path)
			2: directed_rows.push_back(typed_row(KIND_DATA, 8'hbe, 3, BOM_0, BOM_1, 8'hbe));
			3: directed_rows.push_back(typed_row(KIND_EOS, 8'h00, 2, BOM_0, BOM_1, 8'h00));
			default: directed_rows.push_back(typed_row(KIND_DATA, BOM_2, 3, BOM_0, BOM_1, BOM_2));
		endcase
		// end of stream with nothing held, then the low extreme
		directed_rows.push_back(typed_row(KIND_EOS, 8'hff, 0, 8'h00, 8'h00, 8'h00));
		directed_rows.push_back(typed_row(KIND_DATA, 8'h00, 1, 8'h00, 8'h00, 8'h00));
		// four-byte lead with odd continuations, lone continuation byte
		directed_rows.push_back(item_row(KIND_DATA, 8'hff));
		directed_rows.push_back(item_row(KIND_DATA, 8'h80));
		directed_rows.push_back(item_row(KIND_DATA, 8'h3f));
		directed_rows.push_back(item_row(KIND_DATA, 8'hc0));
		directed_rows.push_back(item_row(KIND_EOS, 8'h00));
		directed_rows.push_back(item_row(KIND_DATA, 8'h80));
		directed_rows.push_back(item_row(KIND_DATA, 8'hc3));
		directed_rows.push_back(item_row(KIND_DATA, 8'ha9));
		// end of stream in the middle of a character
		directed_rows.push_back(item_row(KIND_DATA, 8'he2));
		directed_rows.push_back(item_row(KIND_DATA, 8'h82));
		directed_rows.push_back(item_row(KIND_EOS, 8'h55));
		directed_rows.push_back(item_row(KIND_DATA, 8'hac));
		// zero record length with crlf: delimiter before every character
		directed_rows.push_back(cfg_row(REG_RECORD_LENGTH, 32'd0));
		directed_rows.push_back(cfg_row(REG_DELIMITER_LENGTH, 32'd2));
		directed_rows.push_back(cfg_row(REG_DELIMITER_FIRST, 32'd13));
		directed_rows.push_back(cfg_row(REG_DELIMITER_SECOND, 32'd10));
		directed_rows.push_back(item_row(KIND_DATA, 8'h41));
		directed_rows.push_back(item_row(KIND_DATA, 8'hf0));
		directed_rows.push_back(item_row(KIND_DATA, 8'h9f));
		directed_rows.push_back(item_row(KIND_DATA, 8'h98));
		directed_rows.push_back(item_row(KIND_DATA, 8'h80));
		directed_rows.push_back(item_row(KIND_DATA, 8'h7f));
		// delimiter length zero, then three
		directed_rows.push_back(cfg_row(REG_RECORD_LENGTH, 32'd2));
		directed_rows.push_back(cfg_row(REG_DELIMITER_LENGTH, 32'd0));
		directed_rows.push_back(cfg_row(REG_DELIMITER_FIRST, 32'd0));
		directed_rows.push_back(item_row(KIND_DATA, 8'h01));
		directed_rows.push_back(item_row(KIND_DATA, 8'h02));
		directed_rows.push_back(item_row(KIND_DATA, 8'h03));
		directed_rows.push_back(cfg_row(REG_DELIMITER_LENGTH, 32'd3));
		directed_rows.push_back(cfg_row(REG_DELIMITER_SECOND, 32'd255));
		directed_rows.push_back(item_row(KIND_DATA, 8'h04));
		directed_rows.push_back(item_row(KIND_DATA, 8'h05));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (r = 0; r < directed_rows.size(); r++) begin
			row = directed_rows[r];
			if (row.is_cfg) begin
				drain();
				cfg_write(row.reg_idx, row.reg_value);
			end else begin
				send_item(row.item, n_new);
				if (row.n_typed >= 0) begin
					for (k = 0; k < n_new; k++)
						void'(expected_bytes.pop_back());
					for (k = 0; k < row.n_typed; k++)
						expected_bytes.push_back(row.typed[2'(k)]);
				end
			end
		end

		// random phases, each with its own register setting
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			drain();
			case (phase)
				0: rl = 16'd1;
				1: rl = 16'hffff;
				2: rl = 16'd0;
				3: rl = 16'($urandom_range(2, 12));
				4: rl = 16'($urandom_range(1, 40));
				default: rl = 16'($urandom_range(1, 200));
			endcase
			dl = (phase == 1 || phase == 3) ? 2'd2 : 2'($urandom_range(0, 3));
			da = (phase == 3) ? 8'h00 : (phase == 4) ? 8'hff : 8'($urandom_range(0, 255));
			db = (phase == 3) ? 8'hff : (phase == 4) ? 8'h00 : 8'($urandom_range(0, 255));
			cfg_write(REG_RECORD_LENGTH, {16'd0, rl});
			cfg_write(REG_DELIMITER_LENGTH, {30'd0, dl});
			cfg_write(REG_DELIMITER_FIRST, {24'd0, da});
			cfg_write(REG_DELIMITER_SECOND, {24'd0, db});
			// one phase runs with no idling on either side
			calm = (phase == 4);
			paused = 1'b0;
			data_sent = 0;
			while (data_sent < PHASE_BYTES) begin
				// sender holds off mid-phase until the output side has caught up
				if (phase == 2 && !paused && data_sent >= PHASE_BYTES / 2) begin
					paused = 1'b1;
					drain();
				end
				send_char();
			end
		end
		calm = 1'b0;

		// wait for the tail, then report
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
